[rtl/core/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, codes and constants of the thermal camera command controller.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Longest command run that one item can cause
  localparam int RUN_DEPTH = 5;
  localparam int CNT_W     = $clog2(RUN_DEPTH + 1);
  localparam int PTR_W     = $clog2(RUN_DEPTH);

  localparam int CMD_W   = 3;
  localparam int VAL_W   = 8;
  localparam int PWM_W   = 12;
  localparam int TIME_W  = 32;
  localparam int PIDX_W  = 4;
  localparam int ZOOM_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Item kinds
  localparam logic MODE_BOOT = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Camera commands
  localparam logic [CMD_W-1:0] CMD_ANALOG_OFF = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ANALOG_PAL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PALETTE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ZOOM       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FFC        = 3'd4;

  // Flat-field correction modes
  localparam logic [1:0] FFC_NONE   = 2'd0;
  localparam logic [1:0] FFC_AUTO   = 2'd1;
  localparam logic [1:0] FFC_MANUAL = 2'd2;
  localparam logic [1:0] FFC_BOTH   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_PALETTE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FFC_MODE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FFC_IVL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FFC_BOOT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_ARMED = 3'd5;

  localparam logic [PWM_W-1:0]  PRESS_LEVEL = 12'd1500;
  localparam logic [PIDX_W-1:0] PAL_LAST    = 4'd10;
  localparam logic [ZOOM_W-1:0] ZOOM_RESET  = 7'd10;

  typedef struct packed {
    logic                  mode;
    logic [TIME_W-1:0]     time_us;
    logic [PWM_W-1:0]      palette_pwm;
    logic [PWM_W-1:0]      zoom_pwm;
    logic [PWM_W-1:0]      ffc_pwm;
    logic                  armed;
  } tcc_item_t;

  typedef struct packed {
    logic        enabled;
    logic [7:0]  def_palette;
    logic [1:0]  ffc_mode;
    logic [15:0] ffc_interval_ms;
    logic        ffc_on_boot;
    logic        allow_armed;
  } tcc_cfg_t;

  typedef struct packed {
    logic                               load;
    logic [CNT_W-1:0]                   cnt;
    logic [RUN_DEPTH-1:0][CMD_W-1:0]    cmd;
    logic [RUN_DEPTH-1:0][VAL_W-1:0]    val;
  } tcc_run_t;

  // Palette index to camera palette code
  function automatic logic [VAL_W-1:0] pal_code(input logic [PIDX_W-1:0] idx);
    logic [VAL_W-1:0] code;
    case (idx)
      4'd0:    code = 8'h00;
      4'd1:    code = 8'h02;
      4'd2:    code = 8'h03;
      4'd3:    code = 8'h04;
      4'd4:    code = 8'h05;
      4'd5:    code = 8'h06;
      4'd6:    code = 8'h07;
      4'd7:    code = 8'h08;
      4'd8:    code = 8'h09;
      4'd9:    code = 8'h0A;
      4'd10:   code = 8'h0B;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

[rtl/core/thermal_camera_command_controller_core.sv]
// ----------------------------------------------------------------------------
// thermal_camera_command_controller_core
// Turns boot events and periodic RC ticks into thermal camera commands.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall  mode, time_us, palette/zoom/ffc pwm, armed
//  out_     output     out_valid/out_stall  command, value, last
//  cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  An item is held in the input register, is evaluated in one pass
//  and its command run (0..5 commands) is loaded into the result buffer.
//  The result buffer releases one command a cycle while out_stall is low;
//  the next item is evaluated in the cycle the previous run's last command
//  is taken. Reset is synchronous; no clearing pass is needed. Stall on the
//  output backs up into in_stall.
//
module thermal_camera_command_controller_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_mode,
  input  logic [tcc_pkg::TIME_W-1:0]      in_time_us,
  input  logic [tcc_pkg::PWM_W-1:0]       in_palette_pwm,
  input  logic [tcc_pkg::PWM_W-1:0]       in_zoom_pwm,
  input  logic [tcc_pkg::PWM_W-1:0]       in_ffc_pwm,
  input  logic                            in_armed,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tcc_pkg::CMD_W-1:0]       out_command,
  output logic [tcc_pkg::VAL_W-1:0]       out_value,
  output logic                            out_last,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tcc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tcc_pkg::*;

  tcc_item_t item_r;
  logic      in_vld_r;
  tcc_cfg_t  cfg_r;
  tcc_run_t  run;
  logic      run_free;
  logic      go;
  logic      in_take;

  // Evaluate the held item once the result buffer can take its run
  assign go       = in_vld_r && run_free;
  assign in_stall = in_vld_r && !go;
  assign in_take  = in_valid && !in_stall;

  // Writes always accepted; the user must write only while idle, the core does not enforce it
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (go) begin
      in_vld_r <= 1'b0;
    end
  end

  // Capture the item payload on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode        <= in_mode;
      item_r.time_us     <= in_time_us;
      item_r.palette_pwm <= in_palette_pwm;
      item_r.zoom_pwm    <= in_zoom_pwm;
      item_r.ffc_pwm     <= in_ffc_pwm;
      item_r.armed       <= in_armed;
    end
  end

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled         <= 1'b0;
      cfg_r.def_palette     <= '0;
      cfg_r.ffc_mode        <= FFC_BOTH;
      cfg_r.ffc_interval_ms <= 16'd30000;
      cfg_r.ffc_on_boot     <= 1'b1;
      cfg_r.allow_armed     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:      cfg_r.enabled         <= cfg_data[0];
        REG_DEF_PALETTE: cfg_r.def_palette     <= cfg_data[7:0];
        REG_FFC_MODE:    cfg_r.ffc_mode        <= cfg_data[1:0];
        REG_FFC_IVL:     cfg_r.ffc_interval_ms <= cfg_data;
        REG_FFC_BOOT:    cfg_r.ffc_on_boot     <= cfg_data[0];
        REG_ALLOW_ARMED: cfg_r.allow_armed     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Single-pass evaluation against camera state
  tcc_cmd_gen u_gen (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (item_r),
    .cfg   (cfg_r),
    .run   (run)
  );

  // Hand out the command run
  tcc_run_buf u_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .run         (run),
    .free        (run_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_command (out_command),
    .out_value   (out_value),
    .out_last    (out_last)
  );

endmodule

[rtl/core/tcc_zoom_map.sv]
// ----------------------------------------------------------------------------
// tcc_zoom_map
// Maps the zoom knob pulse width to a zoom level of 10..80, ties to even.
// ----------------------------------------------------------------------------
module tcc_zoom_map (
  input  logic [tcc_pkg::PWM_W-1:0]  zoom_pwm,
  output logic [tcc_pkg::ZOOM_W-1:0] zoom_target
);
  import tcc_pkg::*;

  logic [PWM_W-1:0]  pwm_c;
  logic [9:0]        p;
  logic [12:0]       num;
  logic [26:0]       prod;
  logic [6:0]        q;
  logic [12:0]       q100;
  logic [6:0]        r;
  logic              rnd_up;

  always_comb begin
    if (zoom_pwm < 12'd1000) begin
      pwm_c = 12'd1000;
    end else if (zoom_pwm > 12'd2000) begin
      pwm_c = 12'd2000;
    end else begin
      pwm_c = zoom_pwm;
    end
  end

  assign p    = 10'(pwm_c - 12'd1000);
  assign num  = {p, 3'b000} - {3'b000, p};
  // num / 100 by reciprocal, exact for num below 8192
  assign prod = 27'(num) * 27'd10486;
  assign q    = prod[26:20];
  assign q100 = {q, 6'b0} + {1'b0, q, 5'b0} + {4'b0, q, 2'b0};
  assign r    = 7'(num - q100);
  assign rnd_up = (r > 7'd50) || ((r == 7'd50) && q[0]);

  assign zoom_target = ZOOM_RESET + q + {6'b0, rnd_up};

endmodule

[rtl/core/tcc_cmd_gen.sv]
// ----------------------------------------------------------------------------
// tcc_cmd_gen
// Holds camera state and builds the command run for one item in one pass.
// ----------------------------------------------------------------------------
module tcc_cmd_gen (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  tcc_pkg::tcc_item_t item,
  input  tcc_pkg::tcc_cfg_t  cfg,
  output tcc_pkg::tcc_run_t  run
);
  import tcc_pkg::*;

  logic [PIDX_W-1:0] pal_idx_r, pal_idx_nxt;
  logic              pal_prs_r, pal_prs_nxt;
  logic [ZOOM_W-1:0] zoom_r, zoom_nxt;
  logic              ffc_prs_r, ffc_prs_nxt;
  logic [TIME_W-1:0] last_ffc_r, last_ffc_nxt;

  logic [ZOOM_W-1:0] zoom_target;
  logic [16:0]       dprod;
  logic [4:0]        dq;
  logic [7:0]        dq11;
  logic [PIDX_W-1:0] def_idx;
  logic [PIDX_W-1:0] pal_adv;
  logic [TIME_W-1:0] ivl_us;
  logic [TIME_W-1:0] elapsed;
  logic              pal_press, ffc_press;
  logic              auto_on, man_on, auto_hit, man_hit;
  logic [CNT_W-1:0]  n;

  tcc_zoom_map u_zoom (
    .zoom_pwm    (item.zoom_pwm),
    .zoom_target (zoom_target)
  );

  // default_palette mod 11 by reciprocal
  assign dprod   = 17'(cfg.def_palette) * 17'd373;
  assign dq      = dprod[16:12];
  assign dq11    = {dq, 3'b0} + {2'b0, dq, 1'b0} + {3'b0, dq};
  assign def_idx = PIDX_W'(cfg.def_palette - dq11);

  assign pal_adv   = (pal_idx_r == PAL_LAST) ? '0 : pal_idx_r + 4'd1;
  assign ivl_us    = {16'b0, cfg.ffc_interval_ms} * 32'd1000;
  assign elapsed   = item.time_us - last_ffc_r;
  assign pal_press = item.palette_pwm > PRESS_LEVEL;
  assign ffc_press = item.ffc_pwm > PRESS_LEVEL;
  assign auto_on   = (cfg.ffc_mode == FFC_AUTO) || (cfg.ffc_mode == FFC_BOTH);
  assign man_on    = (cfg.ffc_mode == FFC_MANUAL) || (cfg.ffc_mode == FFC_BOTH);
  assign auto_hit  = auto_on && (elapsed >= ivl_us);
  // after an automatic correction the elapsed time restarts from zero
  assign man_hit   = man_on && ffc_press && !ffc_prs_r &&
                     (cfg.allow_armed || !item.armed) &&
                     (auto_hit ? (ivl_us == '0) : (elapsed >= ivl_us));

  always_comb begin
    pal_idx_nxt  = pal_idx_r;
    pal_prs_nxt  = pal_prs_r;
    zoom_nxt     = zoom_r;
    ffc_prs_nxt  = ffc_prs_r;
    last_ffc_nxt = last_ffc_r;
    run          = '0;
    n            = '0;
    if (cfg.enabled) begin
      if (item.mode == MODE_BOOT) begin
        run.cmd[0] = CMD_ANALOG_OFF;
        run.cmd[1] = CMD_ANALOG_PAL;
        run.cmd[2] = CMD_PALETTE;
        run.val[2] = pal_code(def_idx);
        run.cmd[3] = CMD_ZOOM;
        run.val[3] = {1'b0, zoom_r};
        n = CNT_W'(4);
        if (cfg.ffc_on_boot) begin
          run.cmd[4] = CMD_FFC;
          n = CNT_W'(5);
        end
        pal_idx_nxt  = def_idx;
        last_ffc_nxt = item.time_us;
        ffc_prs_nxt  = 1'b0;
      end else begin
        if (pal_press && !pal_prs_r) begin
          run.cmd[n[PTR_W-1:0]] = CMD_PALETTE;
          run.val[n[PTR_W-1:0]] = pal_code(pal_adv);
          n = n + CNT_W'(1);
          pal_idx_nxt = pal_adv;
        end
        pal_prs_nxt = pal_press;
        if (zoom_target != zoom_r) begin
          run.cmd[n[PTR_W-1:0]] = CMD_ZOOM;
          run.val[n[PTR_W-1:0]] = {1'b0, zoom_target};
          n = n + CNT_W'(1);
          zoom_nxt = zoom_target;
        end
        if (auto_hit) begin
          run.cmd[n[PTR_W-1:0]] = CMD_FFC;
          n = n + CNT_W'(1);
        end
        if (man_hit) begin
          run.cmd[n[PTR_W-1:0]] = CMD_FFC;
          n = n + CNT_W'(1);
        end
        if (auto_hit || man_hit) begin
          last_ffc_nxt = item.time_us;
        end
        if (man_on) begin
          ffc_prs_nxt = ffc_press;
        end
      end
    end
    run.load = go;
    run.cnt  = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_idx_r  <= '0;
      pal_prs_r  <= 1'b0;
      zoom_r     <= ZOOM_RESET;
      ffc_prs_r  <= 1'b0;
      last_ffc_r <= '0;
    end else if (go) begin
      pal_idx_r  <= pal_idx_nxt;
      pal_prs_r  <= pal_prs_nxt;
      zoom_r     <= zoom_nxt;
      ffc_prs_r  <= ffc_prs_nxt;
      last_ffc_r <= last_ffc_nxt;
    end
  end

endmodule

[rtl/core/tcc_run_buf.sv]
// ----------------------------------------------------------------------------
// tcc_run_buf
// Result register: holds one command run and hands it out one item a cycle while out_stall is low.
// ----------------------------------------------------------------------------
module tcc_run_buf (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tcc_pkg::tcc_run_t          run,
  output logic                       free,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [tcc_pkg::CMD_W-1:0]  out_command,
  output logic [tcc_pkg::VAL_W-1:0]  out_value,
  output logic                       out_last
);
  import tcc_pkg::*;

  logic [RUN_DEPTH-1:0][CMD_W-1:0] cmd_r;
  logic [RUN_DEPTH-1:0][VAL_W-1:0] val_r;
  logic [CNT_W-1:0]                cnt_r;
  logic [PTR_W-1:0]                ptr_r;
  logic                            take;

  assign out_valid   = CNT_W'(ptr_r) != cnt_r;
  assign out_last    = (CNT_W'(ptr_r) + CNT_W'(1)) == cnt_r;
  assign out_command = cmd_r[ptr_r];
  assign out_value   = val_r[ptr_r];
  assign take        = out_valid && !out_stall;
  // free when empty or when the final item leaves this cycle
  assign free        = !out_valid || (take && out_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ptr_r <= '0;
    end else if (run.load) begin
      cnt_r <= run.cnt;
      ptr_r <= '0;
    end else if (take) begin
      ptr_r <= ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (run.load) begin
      cmd_r <= run.cmd;
      val_r <= run.val;
    end
  end

endmodule

[tb/thermal_camera_command_controller_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_camera_command_controller_core_tb
// Self-checking bench for the camera command controller core.
//
// Items are queued by the sequence below and offered by a clocked driver.
// Every accepted item runs through a local model of the controller (palette
// stepping, zoom mapping, correction scheduling). The model's commands wait in
// a queue and each command leaving the core is checked against the oldest one.
// Register writes happen only while the core is idle. The run covers a
// directed section, then random phases with different register settings and
// handshake pressure on either side.
// ----------------------------------------------------------------------------
module thermal_camera_command_controller_core_tb;
  import tcc_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 16;    // input register + evaluation + margin
  localparam int unsigned HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int unsigned QUIET_LIMIT  = 2000;  // cycles with no handshake at all

  // Index values outside the register map; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // Zoom knob mapping
  localparam int unsigned ZOOM_PWM_LO = 1000;
  localparam int unsigned ZOOM_PWM_HI = 2000;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [VAL_W-1:0] value;
    logic             last;
  } cmd_rec_t;

  // --------------------------------------------------------------------------
  // Clock, reset and core ports
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic                  in_mode        = MODE_BOOT;
  logic [TIME_W-1:0]     in_time_us     = '0;
  logic [PWM_W-1:0]      in_palette_pwm = '0;
  logic [PWM_W-1:0]      in_zoom_pwm    = '0;
  logic [PWM_W-1:0]      in_ffc_pwm     = '0;
  logic                  in_armed       = 1'b0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [CMD_W-1:0]      out_command;
  logic [VAL_W-1:0]      out_value;
  logic                  out_last;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  thermal_camera_command_controller_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_time_us     (in_time_us),
    .in_palette_pwm (in_palette_pwm),
    .in_zoom_pwm    (in_zoom_pwm),
    .in_ffc_pwm     (in_ffc_pwm),
    .in_armed       (in_armed),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_command    (out_command),
    .out_value      (out_value),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  tcc_item_t   item_backlog[$];   // items waiting for the driver
  cmd_rec_t    cmd_due[$];        // commands the core still owes
  tcc_item_t   shown;             // item currently on the input port
  int unsigned err_count    = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          tx_pause     = 1'b0;
  int unsigned hold_budget  = 0;  // total hold-off cycles requested so far
  int unsigned hold_served  = 0;  // hold-off cycles already spent
  int unsigned quiet_cycles = 0;
  logic [TIME_W-1:0] clock_us;    // running time base for random ticks

  // Mirror of the core's registers and state
  tcc_cfg_t          cfg_shadow;
  logic [PIDX_W-1:0] pal_sel;
  logic              pal_held;
  logic [ZOOM_W-1:0] zoom_set;
  logic              ffc_held;
  logic [TIME_W-1:0] ffc_stamp;

  // --------------------------------------------------------------------------
  // Command model
  // --------------------------------------------------------------------------
  function automatic cmd_rec_t cmd_rec(input logic [CMD_W-1:0] command,
                                       input logic [VAL_W-1:0] value);
    cmd_rec_t rec;
    rec.command = command;
    rec.value   = value;
    rec.last    = 1'b0;
    return rec;
  endfunction

  // Camera palette codes skip 0x01
  function automatic logic [VAL_W-1:0] pal_code_of(input logic [PIDX_W-1:0] idx);
    return (idx == 4'd0) ? 8'h00 : {4'd0, idx} + 8'd1;
  endfunction

  // Clamp the knob, scale 0..1000 onto 0..70, round half to even, offset by 10
  function automatic logic [ZOOM_W-1:0] zoom_for(input logic [PWM_W-1:0] pwm);
    int unsigned span, scaled, whole, frac;
    if (pwm < ZOOM_PWM_LO)      span = 0;
    else if (pwm > ZOOM_PWM_HI) span = ZOOM_PWM_HI - ZOOM_PWM_LO;
    else                        span = pwm - ZOOM_PWM_LO;
    scaled = span * 7;
    whole  = scaled / 100;
    frac   = scaled % 100;
    if (frac > 50 || (frac == 50 && (whole % 2) == 1)) whole++;
    return 7'(10 + whole);
  endfunction

  function automatic void predict_commands(input tcc_item_t it);
    cmd_rec_t          run[$];
    logic              pal_down, ffc_down, may_manual;
    logic [TIME_W-1:0] ivl_us;
    logic [ZOOM_W-1:0] zoom_goal;
    if (!cfg_shadow.enabled) return;
    ivl_us = 32'(cfg_shadow.ffc_interval_ms) * 32'd1000;
    if (it.mode == MODE_BOOT) begin
      run.push_back(cmd_rec(CMD_ANALOG_OFF, 8'd0));
      run.push_back(cmd_rec(CMD_ANALOG_PAL, 8'd0));
      pal_sel = 4'(cfg_shadow.def_palette % 8'd11);
      run.push_back(cmd_rec(CMD_PALETTE, pal_code_of(pal_sel)));
      run.push_back(cmd_rec(CMD_ZOOM, {1'b0, zoom_set}));
      if (cfg_shadow.ffc_on_boot) run.push_back(cmd_rec(CMD_FFC, 8'd0));
      ffc_stamp = it.time_us;
      ffc_held  = 1'b0;
    end else begin
      pal_down = it.palette_pwm > PRESS_LEVEL;
      if (pal_down && !pal_held) begin
        pal_sel = (pal_sel == PAL_LAST) ? 4'd0 : pal_sel + 4'd1;
        run.push_back(cmd_rec(CMD_PALETTE, pal_code_of(pal_sel)));
      end
      pal_held = pal_down;

      zoom_goal = zoom_for(it.zoom_pwm);
      if (zoom_goal != zoom_set) begin
        zoom_set = zoom_goal;
        run.push_back(cmd_rec(CMD_ZOOM, {1'b0, zoom_set}));
      end

      if (cfg_shadow.ffc_mode == FFC_AUTO || cfg_shadow.ffc_mode == FFC_BOTH) begin
        if (32'(it.time_us - ffc_stamp) >= ivl_us) begin
          run.push_back(cmd_rec(CMD_FFC, 8'd0));
          ffc_stamp = it.time_us;
        end
      end
      if (cfg_shadow.ffc_mode == FFC_MANUAL || cfg_shadow.ffc_mode == FFC_BOTH) begin
        ffc_down   = it.ffc_pwm > PRESS_LEVEL;
        may_manual = cfg_shadow.allow_armed || !it.armed;
        if (ffc_down && !ffc_held && may_manual &&
            32'(it.time_us - ffc_stamp) >= ivl_us) begin
          run.push_back(cmd_rec(CMD_FFC, 8'd0));
          ffc_stamp = it.time_us;
        end
        ffc_held = ffc_down;
      end
    end
    if (run.size() != 0) run[run.size() - 1].last = 1'b1;
    foreach (run[i]) cmd_due.push_back(run[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    err_count++;
    $display("%0t: mismatch: %s", $time, what);
  endtask

  // Drive the next item on the rising edge; hold a stalled item untouched
  always @(posedge clk) begin : drv
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_commands(shown);
      if (!(in_valid && in_stall)) begin
        if (!tx_pause && item_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          shown          = item_backlog.pop_front();
          in_valid       <= 1'b1;
          in_mode        <= shown.mode;
          in_time_us     <= shown.time_us;
          in_palette_pwm <= shown.palette_pwm;
          in_zoom_pwm    <= shown.zoom_pwm;
          in_ffc_pwm     <= shown.ffc_pwm;
          in_armed       <= shown.armed;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure: a requested hold-off first, random stalls otherwise
  always @(posedge clk) begin : rx_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_served < hold_budget) begin
      out_stall   <= 1'b1;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Compare every taken command with the oldest one owed
  always @(posedge clk) begin : mon
    cmd_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (cmd_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected command %0d value %0d last %0d",
                                out_command, out_value, out_last));
      end else begin
        want = cmd_due.pop_front();
        if (out_command !== want.command)
          flag_mismatch($sformatf("command %0d, expected %0d", out_command, want.command));
        if (out_value !== want.value)
          flag_mismatch($sformatf("value %0d, expected %0d (command %0d)",
                                  out_value, want.value, want.command));
        if (out_last !== want.last)
          flag_mismatch($sformatf("last %0d, expected %0d (command %0d)",
                                  out_last, want.last, want.command));
      end
    end
  end

  // Stop a hung run: nothing moved on any channel for too long
  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d commands owed",
               $time, quiet_cycles, cmd_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence helpers
  // --------------------------------------------------------------------------
  // Write one register; update the mirror once the write is taken
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ENABLE:      cfg_shadow.enabled         = data[0];
      REG_DEF_PALETTE: cfg_shadow.def_palette     = data[7:0];
      REG_FFC_MODE:    cfg_shadow.ffc_mode        = data[1:0];
      REG_FFC_IVL:     cfg_shadow.ffc_interval_ms = data;
      REG_FFC_BOOT:    cfg_shadow.ffc_on_boot     = data[0];
      REG_ALLOW_ARMED: cfg_shadow.allow_armed     = data[0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Wait for every item to be taken and every command to come out, then let
  // the core settle with nothing offered
  task automatic wait_idle();
    while (item_backlog.size() != 0 || in_valid || cmd_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic tcc_item_t mk_item(input logic mode, input logic [TIME_W-1:0] t,
                                        input logic [PWM_W-1:0] pal, input logic [PWM_W-1:0] zoom,
                                        input logic [PWM_W-1:0] ffc, input logic armed);
    tcc_item_t it;
    it.mode        = mode;
    it.time_us     = t;
    it.palette_pwm = pal;
    it.zoom_pwm    = zoom;
    it.ffc_pwm     = ffc;
    it.armed       = armed;
    return it;
  endfunction

  // Mix of full-range widths, the zoom range, the press threshold and zoom ties
  function automatic logic [PWM_W-1:0] random_pwm();
    case ($urandom_range(5))
      0:       return 12'($urandom_range(4095));
      1:       return 12'($urandom_range(ZOOM_PWM_HI, ZOOM_PWM_LO));
      2:       return 12'(1500 + $urandom_range(1));
      3:       return 12'(1050 + 100 * $urandom_range(9));
      4:       return 12'($urandom_range(999));
      default: return 12'($urandom_range(4095, 2001));
    endcase
  endfunction

  // Advance time mostly on the scale of the correction interval, with jumps
  function automatic tcc_item_t random_item(input int unsigned ivl_us, input bit boot);
    int unsigned advance_us;
    case ($urandom_range(9))
      0:       advance_us = $urandom();
      1:       advance_us = 0;
      default: advance_us = $urandom_range(ivl_us * 2 + 2000);
    endcase
    clock_us = clock_us + advance_us;
    return mk_item(boot ? MODE_BOOT : MODE_TICK, clock_us, random_pwm(), random_pwm(),
                   random_pwm(), 1'($urandom_range(1)));
  endfunction

  // One random phase: a boot, then mostly ticks, optional pressure
  task automatic run_phase(input int n_items, input int unsigned tx_pct,
                           input int unsigned rx_pct, input bit squeeze, input bit pause_mid);
    int unsigned ivl_us;
    ivl_us       = cfg_shadow.ffc_interval_ms * 1000;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    clock_us     = $urandom();
    for (int i = 0; i < n_items; i++) begin
      if (pause_mid && i == n_items / 2) begin
        // hold the sender until the core has emptied out
        while (item_backlog.size() != 0) @(negedge clk);
        tx_pause = 1'b1;
        while (in_valid || cmd_due.size() != 0) @(negedge clk);
        @(negedge clk);
        tx_pause = 1'b0;
      end
      item_backlog.push_back(random_item(ivl_us, i == 0 || $urandom_range(24) == 0));
    end
    // starve the receiver while the sender keeps offering: the core fills up
    if (squeeze) hold_budget = hold_budget + HOLD_CYCLES;
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_shadow.enabled         = 1'b0;
    cfg_shadow.def_palette     = 8'd0;
    cfg_shadow.ffc_mode        = FFC_BOTH;
    cfg_shadow.ffc_interval_ms = 16'd30000;
    cfg_shadow.ffc_on_boot     = 1'b1;
    cfg_shadow.allow_armed     = 1'b1;
    pal_sel   = 4'd0;
    pal_held  = 1'b0;
    zoom_set  = ZOOM_RESET;
    ffc_held  = 1'b0;
    ffc_stamp = '0;
    clock_us  = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Drop writes outside the register map; a disabled core stays silent
    write_reg(REG_UNUSED_LO, 16'hFFFF);
    write_reg(REG_UNUSED_HI, 16'h5A5A);
    item_backlog.push_back(mk_item(MODE_BOOT, 32'h0, 12'd4095, 12'd4095, 12'd4095, 1'b1));
    item_backlog.push_back(mk_item(MODE_TICK, 32'hFFFF_FFFF, 12'd4095, 12'd2000, 12'd4095, 1'b0));
    wait_idle();

    // Enable only: everything else runs on its reset value
    write_reg(REG_ENABLE, 16'hFFFF);
    // full boot run close to the top of the time range
    item_backlog.push_back(mk_item(MODE_BOOT, 32'hFFFF_FF00, 12'd0, 12'd0, 12'd0, 1'b0));
    // at threshold, zoom clamped to its current level: no commands
    item_backlog.push_back(mk_item(MODE_TICK, 32'h0000_0100, 12'd1500, 12'd0, 12'd1500, 1'b0));
    // palette press edge; zoom tie rounds up to even
    item_backlog.push_back(mk_item(MODE_TICK, 32'h0000_0200, 12'd1501, 12'd1050, 12'd0, 1'b0));
    // palette still pressed; zoom tie rounds down to even
    item_backlog.push_back(mk_item(MODE_TICK, 32'h0000_0300, 12'd4095, 12'd1150, 12'd0, 1'b1));
    // release; zoom clamped at the top
    item_backlog.push_back(mk_item(MODE_TICK, 32'h0000_0400, 12'd0, 12'd4095, 12'd0, 1'b0));
    item_backlog.push_back(mk_item(MODE_TICK, 32'h0000_0500, 12'd2000, 12'd2000, 12'd0, 1'b0));
    // manual press before the interval has run out
    item_backlog.push_back(mk_item(MODE_TICK, 32'h0000_0600, 12'd2000, 12'd2000, 12'd4095, 1'b1));
    item_backlog.push_back(mk_item(MODE_TICK, 32'h0000_0700, 12'd0, 12'd2000, 12'd0, 1'b1));
    // interval reached across the time wrap: automatic correction
    item_backlog.push_back(mk_item(MODE_TICK, 32'hFFFF_FF00 + 32'd30_000_000, 12'd0, 12'd2000,
                                   12'd0, 1'b0));
    wait_idle();

    // Manual only, no correction at boot, blocked while armed, wide register data
    write_reg(REG_FFC_MODE, 16'hFFFE);
    write_reg(REG_FFC_IVL, 16'h0000);
    write_reg(REG_FFC_BOOT, 16'hFFFE);
    write_reg(REG_ALLOW_ARMED, 16'hFFFE);
    write_reg(REG_DEF_PALETTE, 16'hFFFF);
    item_backlog.push_back(mk_item(MODE_BOOT, 32'h1234_5678, 12'd0, 12'd1500, 12'd4095, 1'b1));
    item_backlog.push_back(mk_item(MODE_TICK, 32'h1234_5678, 12'd0, 12'd1500, 12'd1501, 1'b1));
    item_backlog.push_back(mk_item(MODE_TICK, 32'h1234_5679, 12'd0, 12'd1500, 12'd0, 1'b0));
    item_backlog.push_back(mk_item(MODE_TICK, 32'h1234_5679, 12'd0, 12'd1500, 12'd1501, 1'b0));
    wait_idle();

    // Both corrections on one tick with a zero interval, plus palette and zoom
    write_reg(REG_FFC_MODE, {14'd0, FFC_BOTH});
    write_reg(REG_ALLOW_ARMED, 16'h0001);
    item_backlog.push_back(mk_item(MODE_TICK, 32'h0, 12'd0, 12'd1000, 12'd0, 1'b1));
    item_backlog.push_back(mk_item(MODE_TICK, 32'h0, 12'd4095, 12'd1500, 12'd4095, 1'b1));
    wait_idle();

    // Random phases; each starts from a boot
    write_reg(REG_DEF_PALETTE, 16'h0000);
    write_reg(REG_FFC_IVL, 16'd1);
    write_reg(REG_FFC_BOOT, 16'h0001);
    run_phase(90, 0, 0, 1'b0, 1'b0);

    write_reg(REG_DEF_PALETTE, 16'd10);
    write_reg(REG_FFC_MODE, {14'd0, FFC_AUTO});
    write_reg(REG_FFC_IVL, 16'd0);
    write_reg(REG_FFC_BOOT, 16'h0000);
    write_reg(REG_ALLOW_ARMED, 16'h0000);
    run_phase(90, 45, 0, 1'b0, 1'b0);

    write_reg(REG_DEF_PALETTE, 16'd255);
    write_reg(REG_FFC_MODE, {14'd0, FFC_MANUAL});
    write_reg(REG_FFC_IVL, 16'hFFFF);
    write_reg(REG_FFC_BOOT, 16'h0001);
    run_phase(90, 0, 45, 1'b1, 1'b0);

    write_reg(REG_DEF_PALETTE, 16'($urandom_range(255)));
    write_reg(REG_FFC_MODE, {14'd0, FFC_NONE});
    write_reg(REG_FFC_IVL, 16'd3);
    write_reg(REG_ALLOW_ARMED, 16'h0001);
    run_phase(80, 31, 31, 1'b0, 1'b1);

    write_reg(REG_FFC_MODE, {14'd0, FFC_BOTH});
    write_reg(REG_FFC_IVL, 16'd0);
    write_reg(REG_FFC_BOOT, 16'h0000);
    run_phase(80, 31, 31, 1'b1, 1'b1);

    // Disabled again: items are taken and ignored
    write_reg(REG_ENABLE, 16'h0000);
    run_phase(20, 45, 45, 1'b0, 1'b0);

    write_reg(REG_ENABLE, 16'h0001);
    write_reg(REG_DEF_PALETTE, 16'($urandom_range(255)));
    write_reg(REG_FFC_IVL, 16'($urandom_range(50, 1)));
    write_reg(REG_FFC_BOOT, 16'($urandom_range(1)));
    write_reg(REG_ALLOW_ARMED, 16'($urandom_range(1)));
    run_phase(80, 0, 0, 1'b0, 1'b0);

    if (err_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
